// File: design/assert_macros.svh
// Assertion macros used by the predictor unit design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/swlp_pkg.sv
package swlp_pkg;

	localparam int WINDOW_DEF = 5;
	localparam int SITES_DEF  = 2;
	localparam int QBITS      = 33;

	typedef struct packed {
		logic [1:0]         site;
		logic [31:0]        time_stamp;
		logic signed [31:0] temperature;
		logic signed [31:0] pressure;
		logic signed [31:0] humidity;
	} in_t;

	typedef struct packed {
		logic [1:0]         site_out;
		logic               valid_res;
		logic               degenerate;
		logic signed [31:0] temperature_pred;
		logic signed [31:0] pressure_pred;
		logic signed [31:0] humidity_pred;
	} out_t;

	typedef struct packed {
		logic clr;
		logic acc;
		logic m1_start;
		logic m1_take;
		logic m2_start;
		logic div_start;
		logic degen;
	} lane_ctrl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_ACC,
		S_M1,
		S_W1,
		S_M2,
		S_W2,
		S_DIV,
		S_WD,
		S_OUT
	} state_t;

endpackage

// File: design/swlp_in_if.sv
interface swlp_in_if;
	logic            valid;
	logic            ready;
	swlp_pkg::in_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/swlp_out_if.sv
interface swlp_out_if;
	logic            valid;
	logic            ready;
	swlp_pkg::out_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/swlp_ram.sv
module swlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/swlp_mul.sv
module swlp_mul #(
	parameter int WA = 36,
	parameter int WB = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p,
	output logic                    busy
);
	localparam int CW = (WB > 1) ? $clog2(WB) : 1;

	logic [WA:0]    hi_q;
	logic [WB-1:0]  lo_q;
	logic [WA-1:0]  ma_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [WA:0]    sum;
	logic [WA+WB-1:0] mag;

	// One multiplier bit per cycle on magnitudes; the sign is applied at the end.
	assign sum = hi_q + (lo_q[0] ? {1'b0, ma_q} : '0);
	assign mag = {hi_q[WA-1:0], lo_q};
	assign p   = neg_q ? $signed(-mag) : $signed(mag);
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(WB - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[WA-1] ? -a : a;
			lo_q  <= b[WB-1] ? -b : b;
			hi_q  <= '0;
			neg_q <= a[WA-1] ^ b[WB-1];
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[WA:1]};
			lo_q <= {sum[0], lo_q[WB-1:1]};
		end
	end
endmodule

// File: design/swlp_div.sv
module swlp_div #(
	parameter int WN = 108,
	parameter int WD = 73
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [WN-1:0] num,
	input  logic [WD-1:0]        den,
	output logic signed [31:0]   q,
	output logic                 busy
);
	localparam int QB = swlp_pkg::QBITS;
	localparam int CW = $clog2(QB + 2);

	logic [WN-1:0]   rem_q;
	logic [WD+QB-2:0] d_q;
	logic [WD-1:0]   den_q;
	logic [QB-1:0]   quo_q;
	logic            neg_q;
	logic            ovf_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [31:0]     res_q;
	logic [WN-1:0]   d_x;
	logic [WN-1:0]   d2_x;
	logic [QB:0]     qr;
	logic [QB:0]     lim;
	logic [31:0]     mag32;

	assign d_x  = WN'(d_q);
	assign d2_x = WN'({d_q, 1'b0});
	// Round half away from zero on the magnitude, then clamp to the signed range.
	assign qr   = {1'b0, quo_q} + (({rem_q[WD-1:0], 1'b0} >= {1'b0, den_q}) ? (QB+1)'(1) : '0);
	assign lim  = neg_q ? (QB+1)'(34'h080000000) : (QB+1)'(34'h07FFFFFFF);
	assign mag32 = (ovf_q || qr > lim) ? lim[31:0] : qr[31:0];
	assign q    = $signed(res_q);
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(QB + 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[WN-1] ? -num : num;
			neg_q <= num[WN-1];
			den_q <= den;
			d_q   <= {den, (QB-1)'(0)};
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				ovf_q <= (rem_q >= d2_x);
			end else if (cnt_q <= CW'(QB)) begin
				if (rem_q >= d_x) begin
					rem_q <= rem_q - d_x;
					quo_q <= {quo_q[QB-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QB-2:0], 1'b0};
				end
				d_q <= d_q >> 1;
			end else begin
				res_q <= neg_q ? -mag32 : mag32;
			end
		end
	end
endmodule

// File: design/swlp_lane.sv
module swlp_lane #(
	parameter int WINDOW = swlp_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swlp_pkg::lane_ctrl_t       ctrl,
	input  logic [31:0]                t_s1,
	input  logic signed [31:0]         y_s1,
	input  logic [31+$clog2(WINDOW+1):0] st,
	input  logic [63+2*$clog2(WINDOW+1):0] sxx,
	input  logic signed [33+$clog2(WINDOW+1):0] lever,
	input  logic [63+3*$clog2(WINDOW+1):0] den,
	output logic signed [31:0]         pred,
	output logic                       busy
);
	localparam int LW   = $clog2(WINDOW + 1);
	localparam int WST  = 32 + LW;
	localparam int WSY  = 32 + LW;
	localparam int WSTY = 65 + LW;
	localparam int WXX  = 64 + 2 * LW;
	localparam int WXY  = 65 + 2 * LW;
	localparam int WLV  = 34 + LW;
	localparam int WN   = 99 + 3 * LW;
	localparam int WDN  = 64 + 3 * LW;
	localparam logic signed [WXY-1:0] NW = WXY'(WINDOW);

	logic signed [64:0]     ty_s2;
	logic signed [31:0]     y_s2;
	logic signed [WSY-1:0]  sy_q;
	logic signed [WSTY-1:0] sty_q;
	logic signed [WXY-1:0]  sxy_q;
	logic signed [WXY-1:0]  p1;
	logic signed [WXX+WSY:0] p2;
	logic signed [WN-1:0]   p3;
	logic signed [WN-1:0]   num;
	logic                   b1, b2, b3, bd;

	always_ff @(posedge clk) begin
		ty_s2 <= $signed({1'b0, t_s1}) * y_s1;
		y_s2  <= y_s1;
		if (ctrl.clr) begin
			sy_q  <= '0;
			sty_q <= '0;
		end else if (ctrl.acc) begin
			sy_q  <= sy_q + WSY'(y_s2);
			sty_q <= sty_q + WSTY'(ty_s2);
		end
		if (ctrl.m1_take) begin
			sxy_q <= WXY'(sty_q) * NW - p1;
		end
	end

	swlp_mul #(.WA(WST + 1), .WB(WSY)) u_mul_stsy (
		.clk(clk), .arst_n(arst_n), .start(ctrl.m1_start),
		.a($signed({1'b0, st})), .b(sy_q), .p(p1), .busy(b1)
	);

	swlp_mul #(.WA(WXX + 1), .WB(WSY)) u_mul_sysxx (
		.clk(clk), .arst_n(arst_n), .start(ctrl.m2_start),
		.a($signed({1'b0, sxx})), .b(sy_q), .p(p2), .busy(b2)
	);

	swlp_mul #(.WA(WXY), .WB(WLV)) u_mul_sxylev (
		.clk(clk), .arst_n(arst_n), .start(ctrl.m2_start),
		.a(sxy_q), .b(lever), .p(p3), .busy(b3)
	);

	// A flat time window falls back to the plain mean of the samples.
	assign num = ctrl.degen ? WN'(sy_q) : WN'(p2) + p3;

	swlp_div #(.WN(WN), .WD(WDN)) u_div (
		.clk(clk), .arst_n(arst_n), .start(ctrl.div_start),
		.num(num), .den(den), .q(pred), .busy(bd)
	);

	assign busy = b1 | b2 | b3 | bd;
endmodule

// File: design/sliding_window_linear_predictor_unit.sv
// Sliding-window least-squares predictor for several measurement sites.
// Input channel samp carries one sample transaction: site, time stamp and
// temperature, pressure and humidity in signed Q16.16. Output channel pred
// returns one transaction per sample with the three values extrapolated to
// the newest time plus one, a degenerate flag for a flat time window and
// valid_res cleared for an unknown site (whose predictions read zero).
// A sample for a known site passes through the window read and sums, then
// the bit-serial multipliers of the two product rounds and the
// one-bit-per-cycle divider; three lanes run these in parallel, one per
// measurement. An unknown site skips the arithmetic and goes straight from
// idle to the output state, where its zero result is registered.
// One sample is in flight at a time; the next is taken as soon as the
// previous result sits in the output register, even if the receiver stalls.
// A stalled result holds in the output register until taken.
// Reset empties the history windows (valid bits clear at once, no sweep),
// and entries never written read as zero.
`include "assert_macros.svh"

module sliding_window_linear_predictor_unit #(
	parameter int WINDOW = swlp_pkg::WINDOW_DEF,
	parameter int SITES  = swlp_pkg::SITES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	swlp_in_if.sink      samp,
	swlp_out_if.source   pred
);
	localparam int LW    = $clog2(WINDOW + 1);
	localparam int WST   = 32 + LW;
	localparam int WSTT  = 64 + LW;
	localparam int WXX   = 64 + 2 * LW;
	localparam int WLV   = 34 + LW;
	localparam int WDN   = 64 + 3 * LW;
	localparam int DEPTH = SITES * WINDOW;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int PW    = $clog2(WINDOW);
	localparam int KW    = $clog2(WINDOW + 3);

	swlp_pkg::state_t     state_q, state_d;
	swlp_pkg::lane_ctrl_t ctrl;
	swlp_pkg::in_t        req_q;
	swlp_pkg::out_t       odata_q;

	logic            ok_q;
	logic [SW-1:0]   sidx_q;
	logic [PW-1:0]   wp_q [SITES];
	logic [DEPTH-1:0] vld_q;
	logic [KW-1:0]   k_q;
	logic            rd_s1, rv_s1, prod_s2, ovld_q;
	logic [127:0]    rdata;
	logic [AW-1:0]   base, waddr, raddr;
	logic            site_ok;
	logic            we, re;

	logic [31:0]     t_s1, t_s2;
	logic [63:0]     tt_s2;
	logic [WST-1:0]  st_q;
	logic [WSTT-1:0] stt_q;
	logic [WXX-1:0]  sxx_q, sxx_c;
	logic signed [WLV-1:0] lever_q;
	logic [WDN-1:0]  den_q;
	logic            degen_q;
	logic signed [2*WST+1:0] pss;
	logic            bss;
	logic [32:0]     tnext;

	logic signed [31:0] y_s1 [3];
	logic signed [31:0] lp   [3];
	logic [2:0]      lbusy;
	logic            busy_any;

	assign site_ok = ({1'b0, samp.data.site} >= 3'd1) && ({1'b0, samp.data.site} <= 3'(SITES));
	assign base  = AW'(int'(sidx_q) * WINDOW);
	assign waddr = base + AW'(wp_q[sidx_q]);
	assign raddr = base + AW'(k_q[PW-1:0]);
	assign we    = (state_q == swlp_pkg::S_WRITE);
	assign re    = (state_q == swlp_pkg::S_ACC) && (k_q < KW'(WINDOW));

	swlp_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr),
		.wdata({req_q.humidity, req_q.pressure, req_q.temperature, req_q.time_stamp}),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// Entries never written since reset take part in the sums as zero.
	assign t_s1    = rv_s1 ? rdata[31:0] : '0;
	assign y_s1[0] = rv_s1 ? $signed(rdata[63:32]) : '0;
	assign y_s1[1] = rv_s1 ? $signed(rdata[95:64]) : '0;
	assign y_s1[2] = rv_s1 ? $signed(rdata[127:96]) : '0;

	swlp_mul #(.WA(WST + 1), .WB(WST + 1)) u_mul_stst (
		.clk(clk), .arst_n(arst_n), .start(ctrl.m1_start),
		.a($signed({1'b0, st_q})), .b($signed({1'b0, st_q})), .p(pss), .busy(bss)
	);

	assign sxx_c = WXX'(stt_q) * WXX'(WINDOW) - pss[WXX-1:0];
	assign tnext = {1'b0, req_q.time_stamp} + 33'd1;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		swlp_lane #(.WINDOW(WINDOW)) u_lane (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
			.t_s1(t_s1), .y_s1(y_s1[i]), .st(st_q), .sxx(sxx_q),
			.lever(lever_q), .den(den_q), .pred(lp[i]), .busy(lbusy[i])
		);
	end

	assign busy_any = bss | (|lbusy);

	always_comb begin
		state_d        = state_q;
		ctrl           = '0;
		ctrl.clr       = (state_q == swlp_pkg::S_WRITE);
		ctrl.acc       = prod_s2;
		ctrl.degen     = degen_q;
		case (state_q)
			swlp_pkg::S_IDLE: begin
				if (samp.valid) begin
					state_d = site_ok ? swlp_pkg::S_WRITE : swlp_pkg::S_OUT;
				end
			end
			swlp_pkg::S_WRITE: state_d = swlp_pkg::S_ACC;
			swlp_pkg::S_ACC: begin
				if (k_q == KW'(WINDOW + 1)) begin
					state_d = swlp_pkg::S_M1;
				end
			end
			swlp_pkg::S_M1: begin
				ctrl.m1_start = 1'b1;
				state_d       = swlp_pkg::S_W1;
			end
			swlp_pkg::S_W1: begin
				if (!busy_any) begin
					ctrl.m1_take = 1'b1;
					state_d      = swlp_pkg::S_M2;
				end
			end
			swlp_pkg::S_M2: begin
				ctrl.m2_start = 1'b1;
				state_d       = swlp_pkg::S_W2;
			end
			swlp_pkg::S_W2: begin
				if (!busy_any) begin
					state_d = swlp_pkg::S_DIV;
				end
			end
			swlp_pkg::S_DIV: begin
				ctrl.div_start = 1'b1;
				state_d        = swlp_pkg::S_WD;
			end
			swlp_pkg::S_WD: begin
				if (!busy_any) begin
					state_d = swlp_pkg::S_OUT;
				end
			end
			swlp_pkg::S_OUT: begin
				if (!ovld_q || pred.ready) begin
					state_d = swlp_pkg::S_IDLE;
				end
			end
			default: state_d = swlp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swlp_pkg::S_IDLE;
			k_q     <= '0;
			vld_q   <= '0;
			rd_s1   <= 1'b0;
			rv_s1   <= 1'b0;
			prod_s2 <= 1'b0;
			ovld_q  <= 1'b0;
			for (int s = 0; s < SITES; s++) begin
				wp_q[s] <= '0;
			end
		end else begin
			state_q <= state_d;
			rd_s1   <= re;
			rv_s1   <= re && vld_q[raddr];
			prod_s2 <= rd_s1;
			if (state_q == swlp_pkg::S_WRITE) begin
				k_q           <= '0;
				vld_q[waddr]  <= 1'b1;
				wp_q[sidx_q]  <= (wp_q[sidx_q] == PW'(WINDOW - 1)) ? '0 : wp_q[sidx_q] + 1'b1;
			end else if (state_q == swlp_pkg::S_ACC) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == swlp_pkg::S_OUT && (!ovld_q || pred.ready)) begin
				ovld_q <= 1'b1;
			end else if (pred.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samp.valid && samp.ready) begin
			req_q  <= samp.data;
			ok_q   <= site_ok;
			sidx_q <= SW'(samp.data.site - 2'd1);
		end
		tt_s2 <= t_s1 * t_s1;
		t_s2  <= t_s1;
		if (ctrl.clr) begin
			st_q  <= '0;
			stt_q <= '0;
		end else if (prod_s2) begin
			st_q  <= st_q + WST'(t_s2);
			stt_q <= stt_q + WSTT'(tt_s2);
		end
		if (ctrl.m1_take) begin
			sxx_q   <= sxx_c;
			degen_q <= (sxx_c == '0);
			lever_q <= $signed(WLV'(tnext) * WLV'(WINDOW) - WLV'(st_q));
		end
		if (state_q == swlp_pkg::S_M2) begin
			den_q <= degen_q ? WDN'(WINDOW) : WDN'(sxx_q) * WDN'(WINDOW);
		end
		if (state_q == swlp_pkg::S_OUT && (!ovld_q || pred.ready)) begin
			odata_q.site_out         <= req_q.site;
			odata_q.valid_res        <= ok_q;
			odata_q.degenerate       <= ok_q && degen_q;
			odata_q.temperature_pred <= ok_q ? lp[0] : '0;
			odata_q.pressure_pred    <= ok_q ? lp[1] : '0;
			odata_q.humidity_pred    <= ok_q ? lp[2] : '0;
		end
	end

	assign samp.ready = (state_q == swlp_pkg::S_IDLE);
	assign pred.valid = ovld_q;
	assign pred.data  = odata_q;

	`SWLP_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, samp.valid && samp.ready, state_q != swlp_pkg::S_IDLE, "accepted transaction did not start work")
	`SWLP_ASSERT_IMP(a_idle_units_quiet, clk, arst_n, state_q == swlp_pkg::S_IDLE, !busy_any, "arithmetic unit busy while idle")
	`SWLP_ASSERT_IMP(a_degen_needs_valid, clk, arst_n, pred.valid && pred.data.degenerate, pred.data.valid_res, "degenerate result for unknown site")
	`SWLP_ASSERT_IMP(a_invalid_zero, clk, arst_n, pred.valid && !pred.data.valid_res, pred.data.temperature_pred == 32'sd0 && pred.data.pressure_pred == 32'sd0 && pred.data.humidity_pred == 32'sd0, "unknown site result not zero")
endmodule

// File: tb/sv/sliding_window_linear_predictor_unit_tb.sv
module sliding_window_linear_predictor_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = swlp_pkg::WINDOW_DEF;
	localparam int NSITES = swlp_pkg::SITES_DEF;
	localparam int RANDOM_SAMPLES = 1700;
	localparam int SETTLE_CYCLES = 200;

	localparam logic [1:0] SITE_NONE = 2'd0;
	localparam logic [1:0] SITE_A = 2'd1;
	localparam logic [1:0] SITE_B = 2'd2;
	localparam logic [1:0] SITE_SPARE = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		swlp_pkg::in_t  sample;
		bit             typed;
		swlp_pkg::out_t want;
	} vector_t;

	logic clk;
	logic arst_n;

	swlp_in_if samp();
	swlp_out_if pred();

	sliding_window_linear_predictor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.samp(samp),
		.pred(pred)
	);

	logic [31:0] time_hist [NSITES][WIN];
	logic [31:0] temp_hist [NSITES][WIN];
	logic [31:0] pres_hist [NSITES][WIN];
	logic [31:0] humi_hist [NSITES][WIN];

	swlp_pkg::out_t pending_forecasts[$];
	vector_t        vectors[$];
	int             mismatches = 0;
	bit             calm_stretch = 0;
	bit             stimulus_done = 0;

	always #5 clk = ~clk;

	// Round to nearest with ties away from zero, then clamp to Q16.16 range.
	function automatic logic signed [31:0] round_clamp(wide_t num, wide_t den);
		bit    neg;
		wide_t mag;
		wide_t q;
		wide_t r;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / den;
		r = mag - q * den;
		if (2 * r >= den)
			q = q + 1;
		if (neg) begin
			if (q > 256'sd2147483648)
				q = 256'sd2147483648;
			return 32'(-q);
		end else begin
			if (q > 256'sd2147483647)
				q = 256'sd2147483647;
			return 32'(q);
		end
	endfunction

	function automatic logic signed [31:0] fit_line(logic [31:0] ts[WIN], logic [31:0] ys[WIN],
			output bit flat);
		wide_t n, st, stt, sy, sty, t, y, sxx, sxy, lever;
		n = WIN;
		st = 0;
		stt = 0;
		sy = 0;
		sty = 0;
		for (int i = 0; i < WIN; i++) begin
			t = wide_t'({224'b0, ts[i]});
			y = wide_t'($signed(ys[i]));
			st += t;
			stt += t * t;
			sy += y;
			sty += t * y;
		end
		sxx = n * stt - st * st;
		flat = (sxx == 0);
		if (flat)
			return round_clamp(sy, n);
		sxy = n * sty - st * sy;
		lever = n * (wide_t'({224'b0, ts[WIN-1]}) + 1) - st;
		return round_clamp(sy * sxx + sxy * lever, n * sxx);
	endfunction

	function automatic swlp_pkg::out_t forecast(swlp_pkg::in_t s);
		swlp_pkg::out_t o;
		int   k;
		bit   flat;
		o = '0;
		o.site_out = s.site;
		if (s.site < SITE_A || s.site > NSITES)
			return o;
		k = s.site - 1;
		for (int i = 0; i < WIN - 1; i++) begin
			time_hist[k][i] = time_hist[k][i+1];
			temp_hist[k][i] = temp_hist[k][i+1];
			pres_hist[k][i] = pres_hist[k][i+1];
			humi_hist[k][i] = humi_hist[k][i+1];
		end
		time_hist[k][WIN-1] = s.time_stamp;
		temp_hist[k][WIN-1] = s.temperature;
		pres_hist[k][WIN-1] = s.pressure;
		humi_hist[k][WIN-1] = s.humidity;
		o.temperature_pred = fit_line(time_hist[k], temp_hist[k], flat);
		o.pressure_pred = fit_line(time_hist[k], pres_hist[k], flat);
		o.humidity_pred = fit_line(time_hist[k], humi_hist[k], flat);
		o.valid_res = 1'b1;
		o.degenerate = flat;
		return o;
	endfunction

	function automatic swlp_pkg::in_t mk(logic [1:0] site, logic [31:0] ts, logic [31:0] te,
			logic [31:0] pr, logic [31:0] hu);
		swlp_pkg::in_t s;
		s.site = site;
		s.time_stamp = ts;
		s.temperature = te;
		s.pressure = pr;
		s.humidity = hu;
		return s;
	endfunction

	function automatic swlp_pkg::out_t mk_out(logic [1:0] site, logic v, logic d, logic [31:0] te,
			logic [31:0] pr, logic [31:0] hu);
		swlp_pkg::out_t o;
		o.site_out = site;
		o.valid_res = v;
		o.degenerate = d;
		o.temperature_pred = te;
		o.pressure_pred = pr;
		o.humidity_pred = hu;
		return o;
	endfunction

	task automatic add_vector(swlp_pkg::in_t s, bit typed = 0, swlp_pkg::out_t want = '0);
		vector_t v;
		v.sample = s;
		v.typed = typed;
		v.want = want;
		vectors.push_back(v);
	endtask

	// Random samples: mostly steadily advancing time with smooth drifting values,
	// mixed with equal-time bursts, fully random samples and unknown sites.
	logic [31:0] last_ts [NSITES];
	logic [31:0] last_val [NSITES][3];

	function automatic swlp_pkg::in_t random_sample();
		swlp_pkg::in_t s;
		int  r;
		int  k;
		r = $urandom_range(99);
		s = mk(2'($urandom), $urandom, $urandom, $urandom, $urandom);
		if (r < 8) begin
			s.site = $urandom_range(1) ? SITE_SPARE : SITE_NONE;
			return s;
		end
		s.site = $urandom_range(1) ? SITE_B : SITE_A;
		k = s.site - 1;
		if (r < 18) begin
			// fully random content
		end else if (r < 26) begin
			s.time_stamp = last_ts[k];
		end else begin
			s.time_stamp = last_ts[k] + $urandom_range(1, r < 40 ? 100000 : 60);
			s.temperature = last_val[k][0] + $signed(32'($urandom_range(8191))) - 4096;
			s.pressure = last_val[k][1] + $signed(32'($urandom_range(1 << 20))) - (1 << 19);
			s.humidity = last_val[k][2] + $signed(32'($urandom_range(255))) - 128;
		end
		last_ts[k] = s.time_stamp;
		last_val[k][0] = s.temperature;
		last_val[k][1] = s.pressure;
		last_val[k][2] = s.humidity;
		return s;
	endfunction

	// Source side.
	initial begin
		vector_t v;
		int      idx;
		clk = 0;
		arst_n = 0;
		samp.valid = 0;
		samp.data = '0;
		for (int k = 0; k < NSITES; k++) begin
			last_ts[k] = 0;
			for (int i = 0; i < 3; i++)
				last_val[k][i] = 0;
			for (int i = 0; i < WIN; i++) begin
				time_hist[k][i] = 0;
				temp_hist[k][i] = 0;
				pres_hist[k][i] = 0;
				humi_hist[k][i] = 0;
			end
		end

		// First sample after reset: all times zero, so each value is a flat mean.
		add_vector(mk(SITE_A, 0, 500, -500, 0), 1, mk_out(SITE_A, 1, 1, 100, -100, 0));
		add_vector(mk(SITE_NONE, '1, Q_MAX, Q_MIN, Q_MAX), 1,
			mk_out(SITE_NONE, 0, 0, 0, 0, 0));
		add_vector(mk(SITE_SPARE, 0, Q_MIN, Q_MAX, Q_MIN), 1,
			mk_out(SITE_SPARE, 0, 0, 0, 0, 0));
		add_vector(mk(SITE_A, 1, 1000, 2000, 3000));
		add_vector(mk(SITE_A, 2, 2000, 4000, 6000));
		add_vector(mk(SITE_A, 3, 3000, 6000, 9000));
		add_vector(mk(SITE_A, 4, 4000, 8000, 12000));
		add_vector(mk(SITE_A, 5, 5000, 10000, 15000));
		// Steep swings between the extremes drive the predictions into saturation.
		add_vector(mk(SITE_A, 6, Q_MIN, Q_MAX, Q_MIN));
		add_vector(mk(SITE_A, 7, Q_MAX, Q_MIN, Q_MAX));
		add_vector(mk(SITE_A, 8, Q_MIN, Q_MAX, Q_MIN));
		add_vector(mk(SITE_A, 9, Q_MAX, Q_MIN, Q_MAX));
		// Site two: widest time spread, then a window of equal times.
		add_vector(mk(SITE_B, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MIN));
		add_vector(mk(SITE_B, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MIN));
		add_vector(mk(SITE_B, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MIN));
		add_vector(mk(SITE_B, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MIN));
		add_vector(mk(SITE_B, 32'hFFFF_FFFF, -1, 3, -3));
		add_vector(mk(SITE_B, 32'hFFFF_FFFE, 7, -7, 32'h0001_0000));
		add_vector(mk(SITE_B, 0, -1, 1, 0));
		add_vector(mk(SITE_A, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1));
		add_vector(mk(SITE_SPARE, 32'h1234_5678, 1, 2, 3), 1,
			mk_out(SITE_SPARE, 0, 0, 0, 0, 0));
		for (int i = 0; i < RANDOM_SAMPLES; i++)
			add_vector(random_sample());

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		idx = 0;
		foreach (vectors[i]) begin
			v = vectors[i];
			calm_stretch = (i >= 700 && i < 1000);
			while (!calm_stretch && $urandom_range(99) < 14) begin
				samp.valid <= 0;
				@(posedge clk);
			end
			samp.valid <= 1;
			samp.data <= v.sample;
			do
				@(posedge clk);
			while (!samp.ready);
			// The transaction was accepted at this edge.
			if (v.typed) begin
				void'(forecast(v.sample));
				pending_forecasts.push_back(v.want);
			end else begin
				pending_forecasts.push_back(forecast(v.sample));
			end
		end
		samp.valid <= 0;
		calm_stretch = 0;
		stimulus_done = 1;
	end

	// Sink side.
	always @(posedge clk) begin
		swlp_pkg::out_t got;
		swlp_pkg::out_t want;
		if (arst_n && pred.valid && pred.ready) begin
			got = pred.data;
			if (pending_forecasts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: %p", got);
			end else begin
				want = pending_forecasts.pop_front();
				if (got.site_out !== want.site_out || got.valid_res !== want.valid_res ||
						got.degenerate !== want.degenerate ||
						got.temperature_pred !== want.temperature_pred ||
						got.pressure_pred !== want.pressure_pred ||
						got.humidity_pred !== want.humidity_pred) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at %0t: site %0d/%0d valid %0b/%0b degen %0b/%0b",
							$realtime, want.site_out, got.site_out, want.valid_res,
							got.valid_res, want.degenerate, got.degenerate);
						$display("  temp %0d/%0d press %0d/%0d humid %0d/%0d (expected/actual)",
							want.temperature_pred, got.temperature_pred, want.pressure_pred,
							got.pressure_pred, want.humidity_pred, got.humidity_pred);
					end
				end
			end
		end
		pred.ready <= arst_n && (calm_stretch || $urandom_range(99) >= 14);
	end

	// End of run.
	initial begin
		wait (stimulus_done);
		while (pending_forecasts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
